[design/rcmr_pkg.sv]
// Package for the rod cutting max revenue unit: field widths, microcode types and program ROM.
package rcmr_pkg;

    localparam int LEN_IN_W = 7;
    localparam int VAL_W    = 8;
    localparam logic [VAL_W-1:0] VAL_MAX = 8'd255;

    typedef enum logic [2:0] {
        STEP_WAIT  = 3'd0,
        STEP_ROW   = 3'd1,
        STEP_PRIME = 3'd2,
        STEP_INNER = 3'd3,
        STEP_WRITE = 3'd4,
        STEP_OUT   = 3'd5
    } t_step;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_VALID,
        COND_ROW_DONE,
        COND_INNER_MORE,
        COND_OUT_FREE
    } t_cond;

    typedef enum logic [1:0] {
        RD_LEN_N,
        RD_PRIME,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic {
        WR_ZERO,
        WR_ROW
    } t_wr_sel;

    typedef struct packed {
        t_cond   cond;
        t_step   target;
        logic    hold;
        logic    gate;
        logic    in_rdy;
        logic    ld_len;
        logic    start_row;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    acc;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    inc_row;
        logic    ld_out;
    } t_uop;

    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = '{cond: COND_NEVER, target: STEP_WAIT, hold: 1'b0, gate: 1'b0, in_rdy: 1'b0,
              ld_len: 1'b0, start_row: 1'b0, rd_en: 1'b0, rd_sel: RD_LEN_N, acc: 1'b0,
              wr_en: 1'b0, wr_sel: WR_ZERO, inc_row: 1'b0, ld_out: 1'b0};
        case (step)
            STEP_WAIT: begin
                u.cond   = COND_IN_VALID;
                u.target = STEP_ROW;
                u.hold   = 1'b1;
                u.gate   = 1'b1;
                u.in_rdy = 1'b1;
                u.ld_len = 1'b1;
                u.wr_en  = 1'b1;
                u.wr_sel = WR_ZERO;
            end
            STEP_ROW: begin
                u.cond   = COND_ROW_DONE;
                u.target = STEP_OUT;
                u.rd_en  = 1'b1;
                u.rd_sel = RD_LEN_N;
            end
            STEP_PRIME: begin
                u.start_row = 1'b1;
                u.rd_en     = 1'b1;
                u.rd_sel    = RD_PRIME;
            end
            STEP_INNER: begin
                u.cond   = COND_INNER_MORE;
                u.target = STEP_INNER;
                u.rd_en  = 1'b1;
                u.rd_sel = RD_NEXT;
                u.acc    = 1'b1;
            end
            STEP_WRITE: begin
                u.cond    = COND_ALWAYS;
                u.target  = STEP_ROW;
                u.wr_en   = 1'b1;
                u.wr_sel  = WR_ROW;
                u.inc_row = 1'b1;
            end
            STEP_OUT: begin
                u.cond   = COND_OUT_FREE;
                u.target = STEP_WAIT;
                u.hold   = 1'b1;
                u.gate   = 1'b1;
                u.ld_out = 1'b1;
            end
            default: begin
                u.cond   = COND_ALWAYS;
                u.target = STEP_WAIT;
            end
        endcase
        return u;
    endfunction

endpackage

[design/rcmr_if.sv]
// Handshake interfaces for the rod length input and the revenue output channels.
interface rcmr_in_if;
    logic                          valid;
    logic                          ready;
    logic [rcmr_pkg::LEN_IN_W-1:0] rod_length;

    modport source (output valid, output rod_length, input ready);
    modport sink   (input valid, input rod_length, output ready);
endinterface

interface rcmr_out_if;
    logic                       valid;
    logic                       ready;
    logic [rcmr_pkg::VAL_W-1:0] best_revenue;

    modport source (output valid, output best_revenue, input ready);
    modport sink   (input valid, input best_revenue, output ready);
endinterface

[design/rod_cutting_max_revenue_unit.sv]
// Rod cutting max revenue unit: microcoded sequencer over a bottom-up revenue table.
//
// Usage: one beat on i_in carries a rod length n; one beat on o_out returns the
// best revenue for that rod. Lengths above MAX_LENGTH are clamped to MAX_LENGTH.
// The input is taken only while the sequencer sits in its wait step, so one rod
// is worked at a time. The result sits in an output register; a new rod is taken
// while that result still waits to be taken.
// Each table row runs the inner compare-add step, one table read per cycle from
// the single-port revenue table, plus three control steps per table row.
// The next input beat can land on the same edge as the result beat.
// Stall: if the previous result is still held when the next one is done, the
// sequencer holds in its output step until o_out.ready.
// Reset: i_rst_n low (synchronous) returns the sequencer to the wait step and
// drops o_out.valid. The table needs no clearing; each rod rewrites the entries it reads.
module rod_cutting_max_revenue_unit #(
    parameter int MAX_LENGTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rcmr_in_if.sink           i_in,
    rcmr_out_if.source        o_out
);

    localparam int CW = $clog2(MAX_LENGTH + 2);
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH + 1) : 1;
    localparam int EW = (CW > rcmr_pkg::LEN_IN_W) ? CW : rcmr_pkg::LEN_IN_W;
    localparam int PW = CW + 3;
    localparam int VW = ((PW > rcmr_pkg::VAL_W) ? PW : rcmr_pkg::VAL_W) + 1;

    rcmr_pkg::t_step r_step, n_step;
    rcmr_pkg::t_uop  uop;

    logic [CW-1:0] r_n, r_i, r_len;
    logic [VW-1:0] r_best;
    logic [rcmr_pkg::VAL_W-1:0] r_rd_data;
    logic [rcmr_pkg::VAL_W-1:0] r_out_data;
    logic          r_out_valid;
    logic [rcmr_pkg::VAL_W-1:0] r_best_mem [0:MAX_LENGTH];

    logic          cond_true, act;
    logic          out_free, row_done, inner_more;
    logic [CW-1:0] n_sat;
    logic [PW-1:0] len5, price;
    logic [VW-1:0] cand;
    logic [CW-1:0] rd_addr_w, wr_addr_w;
    logic          mem_rd_en, mem_wr_en;
    logic [rcmr_pkg::VAL_W-1:0] wr_data;

    assign uop        = rcmr_pkg::uop_rom(r_step);
    assign out_free   = !r_out_valid || o_out.ready;
    assign row_done   = r_i > r_n;
    assign inner_more = r_len < r_i;

    assign n_sat = (EW'(i_in.rod_length) > EW'(MAX_LENGTH)) ? CW'(MAX_LENGTH)
                                                            : CW'(i_in.rod_length);

    always_comb begin
        case (uop.cond)
            rcmr_pkg::COND_ALWAYS:     cond_true = 1'b1;
            rcmr_pkg::COND_IN_VALID:   cond_true = i_in.valid;
            rcmr_pkg::COND_ROW_DONE:   cond_true = row_done;
            rcmr_pkg::COND_INNER_MORE: cond_true = inner_more;
            rcmr_pkg::COND_OUT_FREE:   cond_true = out_free;
            default:                   cond_true = 1'b0;
        endcase
        act = !uop.gate || cond_true;
        if (cond_true) begin
            n_step = uop.target;
        end else if (uop.hold) begin
            n_step = r_step;
        end else begin
            n_step = rcmr_pkg::t_step'(r_step + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rcmr_pkg::STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // piece price: 2 for unit length, floor(5*len/2), less one for the uncut rod
    always_comb begin
        len5 = {1'b0, r_len, 2'b00} + {3'b000, r_len};
        if (r_len == CW'(1)) begin
            price = PW'(2);
        end else if (r_len < r_n) begin
            price = len5 >> 1;
        end else begin
            price = (len5 >> 1) - PW'(1);
        end
        cand = VW'(price) + VW'(r_rd_data);
    end

    always_comb begin
        case (uop.rd_sel)
            rcmr_pkg::RD_PRIME: rd_addr_w = r_i - CW'(1);
            rcmr_pkg::RD_NEXT:  rd_addr_w = r_i - r_len - CW'(1);
            default:            rd_addr_w = r_n;
        endcase
        mem_rd_en = uop.rd_en && ((uop.rd_sel != rcmr_pkg::RD_NEXT) || inner_more);

        case (uop.wr_sel)
            rcmr_pkg::WR_ROW: begin
                wr_addr_w = r_i;
                wr_data   = (r_best > VW'(rcmr_pkg::VAL_MAX)) ? rcmr_pkg::VAL_MAX
                                                              : r_best[rcmr_pkg::VAL_W-1:0];
            end
            default: begin
                wr_addr_w = '0;
                wr_data   = '0;
            end
        endcase
        mem_wr_en = uop.wr_en && act;
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_best_mem[wr_addr_w[AW-1:0]] <= wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_best_mem[rd_addr_w[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (uop.ld_len && act) begin
            r_n <= n_sat;
            r_i <= CW'(1);
        end else if (uop.inc_row) begin
            r_i <= r_i + CW'(1);
        end
        if (uop.start_row) begin
            r_best <= '0;
            r_len  <= CW'(1);
        end else if (uop.acc) begin
            if (cand > r_best) begin
                r_best <= cand;
            end
            if (inner_more) begin
                r_len <= r_len + CW'(1);
            end
        end
        if (uop.ld_out && act) begin
            r_out_data <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uop.ld_out && act) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready         = uop.in_rdy;
    assign o_out.valid        = r_out_valid;
    assign o_out.best_revenue = r_out_data;

endmodule
